// ----- hdl/tqc_pkg.sv -----
// ----------------------------------------------------------------------------
// tqc_pkg
// Shared types and codes for the two-queue replacement store: request modes,
// class codes, configuration register indexes, link update kinds and the
// sequencer states.
// ----------------------------------------------------------------------------
package tqc_pkg;

    // Request kinds carried by the mode field.
    typedef enum logic [1:0] {
        MODE_ADD  = 2'd0,
        MODE_GET  = 2'd1,
        MODE_DEL  = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    // Class codes kept with every entry.
    localparam logic [1:0] CLS_HOT  = 2'd0;
    localparam logic [1:0] CLS_WARM = 2'd1;
    localparam logic [1:0] CLS_COLD = 2'd2;
    localparam logic [1:0] CLS_BAD  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HOT_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_WARM_LIMIT = 2'd1;
    localparam logic [1:0] CFG_COLD_LIMIT = 2'd2;
    localparam logic [1:0] CFG_COLD_SLACK = 2'd3;

    // Configuration register contents.
    typedef struct packed {
        logic [4:0] hot_limit;
        logic [4:0] warm_limit;
        logic [4:0] cold_limit;
        logic [3:0] cold_slack;
    } cfg_t;

    // Kinds of read-modify-write on one entry record.
    typedef enum logic [1:0] {
        RMW_NEXT,
        RMW_PREV,
        RMW_PREV_CLS,
        RMW_KILL
    } rmw_kind_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DISPATCH,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_UNL_RD,
        ST_UNL_EV,
        ST_UNL_M2,
        ST_PSH_A,
        ST_PSH_B,
        ST_PSH_C,
        ST_DEL_KILL,
        ST_GET_PUSH,
        ST_GET_CHK,
        ST_GET_DEM,
        ST_ADD_KILL,
        ST_ADD_INS,
        ST_PRUNE_H,
        ST_PRUNE_HD,
        ST_PRUNE_C,
        ST_PRUNE_CK,
        ST_DONE
    } state_t;

endpackage

// ----- hdl/two_queue_cache_replacement_core.sv -----
// ----------------------------------------------------------------------------
// two_queue_cache_replacement_core
// Sequence: a transaction scans every record; a hit or an add then goes on
// through unlinks, pushes and record drops, done as read-modify-write steps
// with control steps between them, all on the one record memory.
// Throughput: one transaction at a time; the next one enters while a result
// waits in the output register.
// Reset: a clearing pass invalidates every record of the memory;
// no transaction is accepted during it, configuration writes are.
// ----------------------------------------------------------------------------
module two_queue_cache_replacement_core #(
    parameter int ENTRIES    = 64,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [4:0]            cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            mode,
    input  logic [KEY_BITS-1:0]   key,
    input  logic [VALUE_BITS-1:0] value_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  found,
    output logic [VALUE_BITS-1:0] value_out
);
    import tqc_pkg::*;

    cfg_t                  cfg_reg;
    logic                  out_valid_reg;
    logic                  found_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  eng_idle;
    logic                  eng_res_valid;
    logic                  eng_found;
    logic [VALUE_BITS-1:0] eng_value;
    logic                  res_take;
    logic                  start;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hot_limit  <= 5'd8;
            cfg_reg.warm_limit <= 5'd8;
            cfg_reg.cold_limit <= 5'd8;
            cfg_reg.cold_slack <= 4'd4;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_HOT_LIMIT:  cfg_reg.hot_limit  <= cfg_data;
                CFG_WARM_LIMIT: cfg_reg.warm_limit <= cfg_data;
                CFG_COLD_LIMIT: cfg_reg.cold_limit <= cfg_data;
                CFG_COLD_SLACK: cfg_reg.cold_slack <= cfg_data[3:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // Input transaction handshake.
    assign in_ready = eng_idle;
    assign start    = in_valid && eng_idle;

    tqc_engine #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .start       (start),
        .start_mode  (mode_t'(mode)),
        .start_key   (key),
        .start_value (value_in),
        .idle        (eng_idle),
        .res_valid   (eng_res_valid),
        .res_take    (res_take),
        .res_found   (eng_found),
        .res_value   (eng_value)
    );

    // Output register: loads when empty or being drained.
    assign res_take = eng_res_valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            found_reg <= eng_found;
            value_reg <= eng_value;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign value_out = value_reg;

endmodule

// ----- hdl/tqc_engine.sv -----
// ----------------------------------------------------------------------------
// tqc_engine
// Entry memory and the sequencer that works on it. A transaction scans all
// records for the key and the lowest free slot, then unlinks, pushes, demotes
// and evicts through read-modify-write steps on the one record memory.
// ----------------------------------------------------------------------------
module tqc_engine #(
    parameter int ENTRIES    = 64,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tqc_pkg::cfg_t          cfg,
    input  logic                   start,
    input  tqc_pkg::mode_t         start_mode,
    input  logic [KEY_BITS-1:0]    start_key,
    input  logic [VALUE_BITS-1:0]  start_value,
    output logic                   idle,
    output logic                   res_valid,
    input  logic                   res_take,
    output logic                   res_found,
    output logic [VALUE_BITS-1:0]  res_value
);
    import tqc_pkg::*;

    localparam int AW   = $clog2(ENTRIES);
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;
    localparam logic [AW:0] ENT_CNT  = (AW + 1)'(ENTRIES);
    localparam logic [AW:0] ENT_LAST = (AW + 1)'(ENTRIES - 1);

    typedef struct packed {
        logic                  vld;
        logic [1:0]            cls;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] val;
        logic [AW-1:0]         nxt;
        logic [AW-1:0]         prv;
    } rec_t;

    // Record memory with registered read data.
    rec_t          mem [ENTRIES];
    rec_t          rd_reg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    rec_t          mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_raddr];
        end
    end

    // Control registers.
    state_t          state_reg, state_next;
    state_t          rmw_ret_reg, rmw_ret_next;
    state_t          push_ret_reg, push_ret_next;
    state_t          unl_ret_reg, unl_ret_next;
    mode_t           mode_reg, mode_next;
    logic [AW:0]     scan_addr_reg, scan_addr_next;
    logic            scan_pend_reg, scan_pend_next;
    logic [AW-1:0]   scan_idx_reg, scan_idx_next;
    logic            hit_reg, hit_next;
    logic [AW-1:0]   hit_idx_reg, hit_idx_next;
    logic            free_ok_reg, free_ok_next;
    logic [AW-1:0]   free_idx_reg, free_idx_next;
    logic [AW-1:0]   rmw_addr_reg, rmw_addr_next;
    rmw_kind_t       rmw_kind_reg, rmw_kind_next;
    logic [AW-1:0]   rmw_val_reg, rmw_val_next;
    logic [1:0]      rmw_cls_reg, rmw_cls_next;
    logic [AW-1:0]   unl_idx_reg, unl_idx_next;
    logic [1:0]      unl_cls_reg, unl_cls_next;
    logic [AW-1:0]   unl_p_reg, unl_p_next;
    logic [AW-1:0]   unl_n_reg, unl_n_next;
    logic [AW-1:0]   push_idx_reg, push_idx_next;
    logic [1:0]      push_cls_reg, push_cls_next;
    logic [AW-1:0]   head_reg [3];
    logic [AW-1:0]   head_next [3];
    logic [AW-1:0]   tail_reg [3];
    logic [AW-1:0]   tail_next [3];
    logic [CW-1:0]   cnt_reg [3];
    logic [CW-1:0]   cnt_next [3];

    // Payload registers.
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [VALUE_BITS-1:0] hit_val_reg, hit_val_next;

    logic [1:0] ev_cls;
    logic [1:0] pc;
    logic [CMPW-1:0] cold_max;

    assign ev_cls   = (rd_reg.cls == CLS_BAD) ? CLS_HOT : rd_reg.cls;
    assign pc       = push_cls_reg;
    assign cold_max = CMPW'(cfg.cold_limit) + CMPW'(cfg.cold_slack);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rmw_ret_reg   <= ST_IDLE;
            push_ret_reg  <= ST_IDLE;
            unl_ret_reg   <= ST_IDLE;
            mode_reg      <= MODE_NONE;
            scan_addr_reg <= '0;
            scan_pend_reg <= 1'b0;
            scan_idx_reg  <= '0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            free_ok_reg   <= 1'b0;
            free_idx_reg  <= '0;
            rmw_addr_reg  <= '0;
            rmw_kind_reg  <= RMW_NEXT;
            rmw_val_reg   <= '0;
            rmw_cls_reg   <= CLS_HOT;
            unl_idx_reg   <= '0;
            unl_cls_reg   <= CLS_HOT;
            unl_p_reg     <= '0;
            unl_n_reg     <= '0;
            push_idx_reg  <= '0;
            push_cls_reg  <= CLS_HOT;
            for (int c = 0; c < 3; c++)
            begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
                cnt_reg[c]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rmw_ret_reg   <= rmw_ret_next;
            push_ret_reg  <= push_ret_next;
            unl_ret_reg   <= unl_ret_next;
            mode_reg      <= mode_next;
            scan_addr_reg <= scan_addr_next;
            scan_pend_reg <= scan_pend_next;
            scan_idx_reg  <= scan_idx_next;
            hit_reg       <= hit_next;
            hit_idx_reg   <= hit_idx_next;
            free_ok_reg   <= free_ok_next;
            free_idx_reg  <= free_idx_next;
            rmw_addr_reg  <= rmw_addr_next;
            rmw_kind_reg  <= rmw_kind_next;
            rmw_val_reg   <= rmw_val_next;
            rmw_cls_reg   <= rmw_cls_next;
            unl_idx_reg   <= unl_idx_next;
            unl_cls_reg   <= unl_cls_next;
            unl_p_reg     <= unl_p_next;
            unl_n_reg     <= unl_n_next;
            push_idx_reg  <= push_idx_next;
            push_cls_reg  <= push_cls_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        val_reg     <= val_next;
        hit_val_reg <= hit_val_next;
    end

    // Sequencer: next state, register updates and memory controls.
    always_comb
    begin
        state_next     = state_reg;
        rmw_ret_next   = rmw_ret_reg;
        push_ret_next  = push_ret_reg;
        unl_ret_next   = unl_ret_reg;
        mode_next      = mode_reg;
        scan_addr_next = scan_addr_reg;
        scan_pend_next = scan_pend_reg;
        scan_idx_next  = scan_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        free_ok_next   = free_ok_reg;
        free_idx_next  = free_idx_reg;
        rmw_addr_next  = rmw_addr_reg;
        rmw_kind_next  = rmw_kind_reg;
        rmw_val_next   = rmw_val_reg;
        rmw_cls_next   = rmw_cls_reg;
        unl_idx_next   = unl_idx_reg;
        unl_cls_next   = unl_cls_reg;
        unl_p_next     = unl_p_reg;
        unl_n_next     = unl_n_reg;
        push_idx_next  = push_idx_reg;
        push_cls_next  = push_cls_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        hit_val_next   = hit_val_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = rmw_addr_reg;
        mem_raddr      = rmw_addr_reg;
        mem_wdata      = rd_reg;
        idle           = 1'b0;
        res_valid      = 1'b0;

        unique case (state_reg)
            // Clearing pass: one record invalidated per cycle after reset.
            ST_CLEAR:
            begin
                mem_we         = 1'b1;
                mem_waddr      = scan_addr_reg[AW-1:0];
                mem_wdata      = '0;
                scan_addr_next = scan_addr_reg + 1'b1;
                if (scan_addr_reg == ENT_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            // Wait for a transaction and capture it.
            ST_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    mode_next      = start_mode;
                    key_next       = start_key;
                    val_next       = start_value;
                    scan_addr_next = '0;
                    scan_pend_next = 1'b0;
                    hit_next       = 1'b0;
                    free_ok_next   = 1'b0;
                    hit_val_next   = '0;
                    state_next     = ST_SCAN;
                end
            end

            // Pipelined scan: issue one read and check the previous one.
            ST_SCAN:
            begin
                if (scan_pend_reg)
                begin
                    if (rd_reg.vld && (rd_reg.key == key_reg) && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = scan_idx_reg;
                        hit_val_next = rd_reg.val;
                    end
                    if (!rd_reg.vld && !free_ok_reg)
                    begin
                        free_ok_next  = 1'b1;
                        free_idx_next = scan_idx_reg;
                    end
                end
                if (scan_addr_reg != ENT_CNT)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = scan_addr_reg[AW-1:0];
                    scan_pend_next = 1'b1;
                    scan_idx_next  = scan_addr_reg[AW-1:0];
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                else
                begin
                    scan_pend_next = 1'b0;
                    if (!scan_pend_reg)
                    begin
                        state_next = ST_DISPATCH;
                    end
                end
            end

            // Choose the flow for the request kind.
            ST_DISPATCH:
            begin
                unl_idx_next = hit_idx_reg;
                unique case (mode_reg)
                    MODE_ADD:
                    begin
                        unl_ret_next = ST_ADD_KILL;
                        state_next   = hit_reg ? ST_UNL_RD : ST_ADD_INS;
                    end
                    MODE_GET:
                    begin
                        unl_ret_next = ST_GET_PUSH;
                        state_next   = hit_reg ? ST_UNL_RD : ST_DONE;
                    end
                    MODE_DEL:
                    begin
                        unl_ret_next = ST_DEL_KILL;
                        state_next   = hit_reg ? ST_UNL_RD : ST_DONE;
                    end
                    MODE_NONE:
                    begin
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            // Generic read-modify-write of one record.
            ST_RMW_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = rmw_addr_reg;
                state_next = ST_RMW_WR;
            end

            ST_RMW_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = rmw_addr_reg;
                mem_wdata = rd_reg;
                unique case (rmw_kind_reg)
                    RMW_NEXT:
                    begin
                        mem_wdata.nxt = rmw_val_reg;
                    end
                    RMW_PREV:
                    begin
                        mem_wdata.prv = rmw_val_reg;
                    end
                    RMW_PREV_CLS:
                    begin
                        mem_wdata.prv = rmw_val_reg;
                        mem_wdata.cls = rmw_cls_reg;
                    end
                    RMW_KILL:
                    begin
                        mem_wdata.vld = 1'b0;
                    end
                    default:
                    begin
                        mem_wdata = rd_reg;
                    end
                endcase
                state_next = rmw_ret_reg;
            end

            // Unlink: read the record to learn its class and neighbors.
            ST_UNL_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = unl_idx_reg;
                state_next = ST_UNL_EV;
            end

            ST_UNL_EV:
            begin
                unl_cls_next = ev_cls;
                unl_p_next   = rd_reg.prv;
                unl_n_next   = rd_reg.nxt;
                state_next   = unl_ret_reg;
                if (cnt_reg[ev_cls] != '0)
                begin
                    cnt_next[ev_cls] = cnt_reg[ev_cls] - 1'b1;
                    priority if (cnt_reg[ev_cls] == CW'(1))
                    begin
                        head_next[ev_cls] = '0;
                        tail_next[ev_cls] = '0;
                    end
                    else if (unl_idx_reg == head_reg[ev_cls])
                    begin
                        head_next[ev_cls] = rd_reg.nxt;
                    end
                    else if (unl_idx_reg == tail_reg[ev_cls])
                    begin
                        tail_next[ev_cls] = rd_reg.prv;
                    end
                    else
                    begin
                        rmw_addr_next = rd_reg.prv;
                        rmw_kind_next = RMW_NEXT;
                        rmw_val_next  = rd_reg.nxt;
                        rmw_ret_next  = ST_UNL_M2;
                        state_next    = ST_RMW_RD;
                    end
                end
            end

            // Second half of a middle unlink: fix the successor's back link.
            ST_UNL_M2:
            begin
                rmw_addr_next = unl_n_reg;
                rmw_kind_next = RMW_PREV;
                rmw_val_next  = unl_p_reg;
                rmw_ret_next  = unl_ret_reg;
                state_next    = ST_RMW_RD;
            end

            // Push: link behind the current tail of the class.
            ST_PSH_A:
            begin
                if (cnt_reg[pc] != '0)
                begin
                    rmw_addr_next = tail_reg[pc];
                    rmw_kind_next = RMW_NEXT;
                    rmw_val_next  = push_idx_reg;
                    rmw_ret_next  = ST_PSH_B;
                    state_next    = ST_RMW_RD;
                end
                else
                begin
                    state_next = ST_PSH_B;
                end
            end

            ST_PSH_B:
            begin
                rmw_addr_next = push_idx_reg;
                rmw_kind_next = RMW_PREV_CLS;
                rmw_val_next  = tail_reg[pc];
                rmw_cls_next  = pc;
                rmw_ret_next  = ST_PSH_C;
                state_next    = ST_RMW_RD;
            end

            ST_PSH_C:
            begin
                if (cnt_reg[pc] == '0)
                begin
                    head_next[pc] = push_idx_reg;
                end
                tail_next[pc] = push_idx_reg;
                cnt_next[pc]  = cnt_reg[pc] + 1'b1;
                state_next    = push_ret_reg;
            end

            // Delete: drop the unlinked record.
            ST_DEL_KILL:
            begin
                rmw_addr_next = hit_idx_reg;
                rmw_kind_next = RMW_KILL;
                rmw_ret_next  = ST_DONE;
                state_next    = ST_RMW_RD;
            end

            // Get hit: requeue; cold goes to warm, over-limit warm demotes.
            ST_GET_PUSH:
            begin
                push_idx_next = hit_idx_reg;
                state_next    = ST_PSH_A;
                if (unl_cls_reg == CLS_COLD)
                begin
                    push_cls_next = CLS_WARM;
                    push_ret_next = ST_GET_CHK;
                end
                else
                begin
                    push_cls_next = unl_cls_reg;
                    push_ret_next = ST_DONE;
                end
            end

            ST_GET_CHK:
            begin
                if (CMPW'(cnt_reg[CLS_WARM]) > CMPW'(cfg.warm_limit))
                begin
                    unl_idx_next = head_reg[CLS_WARM];
                    unl_ret_next = ST_GET_DEM;
                    state_next   = ST_UNL_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_GET_DEM:
            begin
                push_idx_next = unl_idx_reg;
                push_cls_next = CLS_COLD;
                push_ret_next = ST_DONE;
                state_next    = ST_PSH_A;
            end

            // Add: drop the old copy, then store in the lowest free slot.
            ST_ADD_KILL:
            begin
                rmw_addr_next = hit_idx_reg;
                rmw_kind_next = RMW_KILL;
                rmw_ret_next  = ST_ADD_INS;
                state_next    = ST_RMW_RD;
            end

            ST_ADD_INS:
            begin
                mem_wdata     = '0;
                mem_wdata.vld = 1'b1;
                mem_wdata.cls = CLS_HOT;
                mem_wdata.key = key_reg;
                mem_wdata.val = val_reg;
                push_cls_next = CLS_HOT;
                push_ret_next = ST_PRUNE_H;
                priority if (hit_reg && (!free_ok_reg || (hit_idx_reg < free_idx_reg)))
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = hit_idx_reg;
                    push_idx_next = hit_idx_reg;
                    state_next    = ST_PSH_A;
                end
                else if (free_ok_reg)
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = free_idx_reg;
                    push_idx_next = free_idx_reg;
                    state_next    = ST_PSH_A;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            // Prune: demote oldest hot entries over limit, then check cold.
            ST_PRUNE_H:
            begin
                priority if (CMPW'(cnt_reg[CLS_HOT]) > CMPW'(cfg.hot_limit))
                begin
                    unl_idx_next = head_reg[CLS_HOT];
                    unl_ret_next = ST_PRUNE_HD;
                    state_next   = ST_UNL_RD;
                end
                else if (CMPW'(cnt_reg[CLS_COLD]) > cold_max)
                begin
                    state_next = ST_PRUNE_C;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_PRUNE_HD:
            begin
                push_idx_next = unl_idx_reg;
                push_cls_next = CLS_COLD;
                push_ret_next = ST_PRUNE_H;
                state_next    = ST_PSH_A;
            end

            // Evict oldest cold entries until cold is back at its limit.
            ST_PRUNE_C:
            begin
                if (CMPW'(cnt_reg[CLS_COLD]) > CMPW'(cfg.cold_limit))
                begin
                    unl_idx_next = head_reg[CLS_COLD];
                    unl_ret_next = ST_PRUNE_CK;
                    state_next   = ST_UNL_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_PRUNE_CK:
            begin
                rmw_addr_next = unl_idx_reg;
                rmw_kind_next = RMW_KILL;
                rmw_ret_next  = ST_PRUNE_C;
                state_next    = ST_RMW_RD;
            end

            // Hand the result to the output register.
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result fields.
    assign res_found = (mode_reg != MODE_NONE) && hit_reg;
    assign res_value = ((mode_reg == MODE_GET) && hit_reg) ? hit_val_reg : '0;

endmodule

// ----- hdl/tqc_checker.sv -----
// ----------------------------------------------------------------------------
// tqc_checker
// Port-level checks for the two-queue store: outstanding transactions,
// busy behavior after acceptance and result formatting.
// ----------------------------------------------------------------------------
module tqc_checker #(
    parameter int VALUE_BITS = 32
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  found,
    input logic [VALUE_BITS-1:0] value_out
);
    logic [1:0] pend_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Count transactions accepted but not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else if (in_acc && !out_acc)
        begin
            pend_reg <= pend_reg + 2'd1;
        end
        else if (out_acc && !in_acc)
        begin
            pend_reg <= pend_reg - 2'd1;
        end
    end

    // A result is never shown without a transaction behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != 2'd0))
        else $error("result without an outstanding transaction");

    // The engine is busy right after it takes a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("ready right after acceptance");

    // At most one transaction in the engine and one in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg == 2'd2) |-> !in_ready)
        else $error("accepting with both stages full");

    // A miss carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (value_out == '0))
        else $error("nonzero value without found");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(found) && $stable(value_out)))
        else $error("stalled result changed");

endmodule

bind two_queue_cache_replacement_core tqc_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_tqc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .value_out (value_out)
);
